// ===== design/cpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types and constants for the collision pair test block.
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int FIELD_W = 48;
    localparam int CMD_W   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_BOX_BOX       = 3'd0,
        CMD_BOX_SPHERE    = 3'd1,
        CMD_SPHERE_SPHERE = 3'd2,
        CMD_POINT_BOX     = 3'd3,
        CMD_POINT_SPHERE  = 3'd4
    } cmd_t;

    typedef struct packed {
        logic bb_ok;
        logic pb_ok;
    } axis_flags_t;

endpackage

// ===== design/cpt_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_axis
// Per-axis interval compares and the distance magnitude used by the
// sphere tests, centre to centre, point to centre or centre to clamped box point.
// ----------------------------------------------------------------------------
module cpt_axis
    import cpt_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic signed [COORD_BITS-1:0] a_p,
    input  logic        [COORD_BITS-1:0] a_e,
    input  logic signed [COORD_BITS-1:0] b_p,
    input  logic        [COORD_BITS-1:0] b_e,
    input  logic                         clamp_sel,
    output axis_flags_t                  flags,
    output logic        [COORD_BITS+1:0] span
);

    localparam int W = COORD_BITS + 3;

    logic signed [W-1:0] ap_x;
    logic signed [W-1:0] bp_x;
    logic signed [W-1:0] a_hi;
    logic signed [W-1:0] b_hi;
    logic signed [W-1:0] diff;
    logic signed [W-1:0] mag;

    assign ap_x = W'(a_p);
    assign bp_x = W'(b_p);
    assign a_hi = ap_x + $signed({3'b000, a_e});
    assign b_hi = bp_x + $signed({3'b000, b_e});

    assign flags.bb_ok = (ap_x < b_hi) && (a_hi > bp_x);
    assign flags.pb_ok = (ap_x >= bp_x) && (ap_x <= b_hi);

    assign diff = ap_x - bp_x;

    always_comb
    begin
        if (clamp_sel)
        begin
            if (bp_x < ap_x)
            begin
                mag = ap_x - bp_x;
            end
            else if (bp_x > a_hi)
            begin
                mag = bp_x - a_hi;
            end
            else
            begin
                mag = '0;
            end
        end
        else
        begin
            mag = (diff < 0) ? -diff : diff;
        end
    end

    assign span = mag[COORD_BITS+1:0];

endmodule

// ===== design/cpt_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_eval
// Squares the per-axis distances, compares their sum against the squared
// radius (both radii summed for sphere pairs) and selects the hit flag for the pair kind.
// ----------------------------------------------------------------------------
module cpt_eval
    import cpt_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  cmd_t                             cmd,
    input  axis_flags_t [2:0]                flags,
    input  logic        [2:0][COORD_BITS+1:0] span,
    input  logic        [COORD_BITS-1:0]     a_r,
    input  logic        [COORD_BITS-1:0]     b_r,
    output logic                             hit
);

    localparam int SQ_W  = 2 * (COORD_BITS + 2);
    localparam int SUM_W = SQ_W + 2;
    localparam int T_W   = COORD_BITS + 1;

    logic [2:0][SQ_W-1:0] sq;
    logic [SUM_W-1:0]     sum;
    logic [T_W-1:0]       thr;
    logic [SUM_W-1:0]     thr_sq;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq[k] = SQ_W'(span[k]) * SQ_W'(span[k]);
        end
    end

    assign sum = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);

    always_comb
    begin
        if (cmd == CMD_SPHERE_SPHERE)
        begin
            thr = T_W'(a_r) + T_W'(b_r);
        end
        else
        begin
            thr = T_W'(b_r);
        end
    end

    assign thr_sq = SUM_W'(thr) * SUM_W'(thr);

    always_comb
    begin
        case (cmd)
            CMD_BOX_BOX:       hit = flags[0].bb_ok && flags[1].bb_ok && flags[2].bb_ok;
            CMD_BOX_SPHERE:    hit = sum < thr_sq;
            CMD_SPHERE_SPHERE: hit = sum <= thr_sq;
            CMD_POINT_BOX:     hit = flags[0].pb_ok && flags[1].pb_ok && flags[2].pb_ok;
            CMD_POINT_SPHERE:  hit = sum < thr_sq;
            default:           hit = 1'b0;
        endcase
    end

endmodule

// ===== design/collision_pair_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// collision_pair_test
// Streaming box and sphere pair test: one hit flag for each input item.
// ----------------------------------------------------------------------------
// An item is registered when accepted, and its hit flag is registered in
// the result register once the result stage can advance.
// Throughput: one item per cycle while out_ready is high, set by the single
// compute stage between the input register and the result register.
// Reset clears both valid flags; the payload registers are not reset.
module collision_pair_test
    import cpt_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [FIELD_W-1:0] a_pos,
    input  logic [FIELD_W-1:0] a_ext,
    input  logic [FIELD_W-1:0] b_pos,
    input  logic [FIELD_W-1:0] b_ext,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit
);

    localparam int PAD_W = (3 * COORD_BITS > FIELD_W) ? 3 * COORD_BITS : FIELD_W;

    logic               s1_valid_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [FIELD_W-1:0] a_pos_reg;
    logic [FIELD_W-1:0] a_ext_reg;
    logic [FIELD_W-1:0] b_pos_reg;
    logic [FIELD_W-1:0] b_ext_reg;
    logic               out_valid_reg;
    logic               hit_reg;
    logic               hit_next;
    logic               adv;

    logic [PAD_W-1:0] a_pos_w;
    logic [PAD_W-1:0] a_ext_w;
    logic [PAD_W-1:0] b_pos_w;
    logic [PAD_W-1:0] b_ext_w;

    cmd_t                          cmd_q;
    logic                          clamp_sel;
    axis_flags_t [2:0]             flags;
    logic [2:0][COORD_BITS+1:0]    span;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || adv;

    assign a_pos_w = PAD_W'(a_pos_reg);
    assign a_ext_w = PAD_W'(a_ext_reg);
    assign b_pos_w = PAD_W'(b_pos_reg);
    assign b_ext_w = PAD_W'(b_ext_reg);

    assign cmd_q     = cmd_t'(cmd_reg);
    assign clamp_sel = (cmd_q == CMD_BOX_SPHERE);

    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        cpt_axis #(
            .COORD_BITS (COORD_BITS)
        ) u_axis (
            .a_p       ($signed(a_pos_w[k*COORD_BITS +: COORD_BITS])),
            .a_e       (a_ext_w[k*COORD_BITS +: COORD_BITS]),
            .b_p       ($signed(b_pos_w[k*COORD_BITS +: COORD_BITS])),
            .b_e       (b_ext_w[k*COORD_BITS +: COORD_BITS]),
            .clamp_sel (clamp_sel),
            .flags     (flags[k]),
            .span      (span[k])
        );
    end

    cpt_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_eval (
        .cmd   (cmd_q),
        .flags (flags),
        .span  (span),
        .a_r   (a_ext_w[COORD_BITS-1:0]),
        .b_r   (b_ext_w[COORD_BITS-1:0]),
        .hit   (hit_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= cmd;
            a_pos_reg <= a_pos;
            a_ext_reg <= a_ext;
            b_pos_reg <= b_pos;
            b_ext_reg <= b_ext;
        end
        if (adv && s1_valid_reg)
        begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

`ifndef SYNTH
    a_free_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("Input refused while the input stage is empty.");

    a_item_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && adv) |=> out_valid)
        else $error("Registered item did not reach the result register.");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("Input accepted while both stages are stalled.");

    a_unknown_cmd_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && adv && (cmd_reg > CMD_POINT_SPHERE)) |=> !hit)
        else $error("Hit reported for an unknown pair kind.");
`endif

endmodule
